### hdl/jdpc_pkg.sv
package jdpc_pkg;

   // field widths
   localparam int STICK_W = 8;
   localparam int MOVE_W  = 2;
   localparam int DZ_W    = 8;
   localparam int TICK_W  = 10;
   localparam int HOLD_W  = 16;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   typedef logic signed [STICK_W-1:0] stick_type;
   typedef logic signed [MOVE_W-1:0]  move_type;
   typedef logic [DZ_W-1:0]           dz_type;
   typedef logic [TICK_W-1:0]         tick_type;
   typedef logic [HOLD_W-1:0]         hold_type;
   typedef logic [CSR_ADDR_W-1:0]     csr_addr_type;
   typedef logic [CSR_DATA_W-1:0]     csr_data_type;

   // register indexes
   localparam csr_addr_type REG_DEAD_ZONE  = 2'd0;
   localparam csr_addr_type REG_TICK_MS    = 2'd1;
   localparam csr_addr_type REG_QUIT_HOLD  = 2'd2;
   localparam csr_addr_type REG_RESET_HOLD = 2'd3;

   // register reset values
   localparam dz_type   DEAD_ZONE_RST  = 8'd80;
   localparam tick_type TICK_MS_RST    = 10'd16;
   localparam hold_type QUIT_HOLD_RST  = 16'd3000;
   localparam hold_type RESET_HOLD_RST = 16'd1000;

   localparam dz_type   DZ_FLOOR = 8'd80;
   localparam hold_type HELD_MAX = 16'hFFFF;

   // move codes
   localparam move_type MOVE_NONE = 2'sb00;
   localparam move_type MOVE_POS  = 2'sb01;
   localparam move_type MOVE_NEG  = 2'sb11;

endpackage

### hdl/jdpc_req_if.sv
interface jdpc_req_if import jdpc_pkg::*; ();
   logic      valid;
   logic      ready;
   stick_type stick_x;
   stick_type stick_y;
   logic      button_down;

   modport source (output valid, stick_x, stick_y, button_down, input ready);
   modport sink   (input valid, stick_x, stick_y, button_down, output ready);
endinterface

### hdl/jdpc_rsp_if.sv
interface jdpc_rsp_if import jdpc_pkg::*; ();
   logic     valid;
   logic     ready;
   move_type move;
   logic     pause_pulse;
   logic     reset_pulse;
   logic     quit_pulse;

   modport source (output valid, move, pause_pulse, reset_pulse, quit_pulse, input ready);
   modport sink   (input valid, move, pause_pulse, reset_pulse, quit_pulse, output ready);
endinterface

### hdl/jdpc_csr_if.sv
interface jdpc_csr_if import jdpc_pkg::*; ();
   logic         valid;
   logic         ready;
   csr_addr_type addr;
   csr_data_type wdata;

   modport source (output valid, addr, wdata, input ready);
   modport sink   (input valid, addr, wdata, output ready);
endinterface

### hdl/joystick_deadzone_press_classifier.sv
// An accepted req beat goes through the input register and the result register to its rsp beat.
// Throughput: one beat per cycle; a new req beat is taken every cycle unless rsp stalls
// with both the input and result registers full.
// Reset (synchronous, active high): empties both stages, clears the press state and the
// hold counter, and loads dead_zone=80, tick_ms=16, quit_hold_ms=3000, reset_hold_ms=1000.
module joystick_deadzone_press_classifier import jdpc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   jdpc_req_if.sink     req_chan,
   jdpc_rsp_if.source   rsp_chan,
   jdpc_csr_if.sink     csr_chan
);

   // ---------------------------------------------------------------
   // Configuration registers. Always ready; writes take effect in the next cycle.
   // ---------------------------------------------------------------
   dz_type   dead_zone_ff, dead_zone_in;
   tick_type tick_ms_ff, tick_ms_in;
   hold_type quit_hold_ff, quit_hold_in;
   hold_type reset_hold_ff, reset_hold_in;
   logic     csr_wr;

   assign csr_chan.ready = 1'b1;
   assign csr_wr = csr_chan.valid & csr_chan.ready;

   always_comb begin
      dead_zone_in  = dead_zone_ff;
      tick_ms_in    = tick_ms_ff;
      quit_hold_in  = quit_hold_ff;
      reset_hold_in = reset_hold_ff;
      if (csr_wr) begin
         unique case (csr_chan.addr)
            REG_DEAD_ZONE:  dead_zone_in  = csr_chan.wdata[DZ_W-1:0];
            REG_TICK_MS:    tick_ms_in    = csr_chan.wdata[TICK_W-1:0];
            REG_QUIT_HOLD:  quit_hold_in  = csr_chan.wdata[HOLD_W-1:0];
            REG_RESET_HOLD: reset_hold_in = csr_chan.wdata[HOLD_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dead_zone_ff  <= DEAD_ZONE_RST;
         tick_ms_ff    <= TICK_MS_RST;
         quit_hold_ff  <= QUIT_HOLD_RST;
         reset_hold_ff <= RESET_HOLD_RST;
      end else begin
         dead_zone_ff  <= dead_zone_in;
         tick_ms_ff    <= tick_ms_in;
         quit_hold_ff  <= quit_hold_in;
         reset_hold_ff <= reset_hold_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage handshake. The result register moves when it is empty or
   // being drained; the input register moves when it is empty or its
   // beat is moving into the result register.
   // ---------------------------------------------------------------
   logic      s0_valid_ff, s0_valid_in;
   stick_type s0_x_ff, s0_x_in;
   stick_type s0_y_ff, s0_y_in;
   logic      s0_btn_ff, s0_btn_in;

   logic      s1_valid_ff, s1_valid_in;
   move_type  s1_move_ff, s1_move_in;
   logic      s1_pause_ff, s1_pause_in;
   logic      s1_reset_ff, s1_reset_in;
   logic      s1_quit_ff, s1_quit_in;

   logic      s1_open;   // result register can take a beat
   logic      s0_fire;   // input register beat moves into result register
   logic      req_take;

   assign s1_open  = ~s1_valid_ff | rsp_chan.ready;
   assign s0_fire  = s0_valid_ff & s1_open;
   assign req_chan.ready = ~s0_valid_ff | s1_open;
   assign req_take = req_chan.valid & req_chan.ready;

   assign s0_valid_in = req_take | (s0_valid_ff & ~s1_open);
   assign s0_x_in     = req_take ? req_chan.stick_x     : s0_x_ff;
   assign s0_y_in     = req_take ? req_chan.stick_y     : s0_y_ff;
   assign s0_btn_in   = req_take ? req_chan.button_down : s0_btn_ff;

   // ---------------------------------------------------------------
   // Stick classification: larger magnitude wins, X on ties.
   // Magnitudes fit 8 bits unsigned (-128 gives 128).
   // ---------------------------------------------------------------
   logic [STICK_W-1:0] mag_x, mag_y;
   stick_type          win_v;
   dz_type             dz_eff;
   logic signed [STICK_W:0] win_ext, dz_pos, dz_neg;
   move_type           move_calc;

   assign mag_x  = s0_x_ff[STICK_W-1] ? (~s0_x_ff + 1'b1) : s0_x_ff;
   assign mag_y  = s0_y_ff[STICK_W-1] ? (~s0_y_ff + 1'b1) : s0_y_ff;
   assign win_v  = (mag_x >= mag_y) ? s0_x_ff : s0_y_ff;
   assign dz_eff = (dead_zone_ff < DZ_FLOOR) ? DZ_FLOOR : dead_zone_ff;

   assign win_ext = {win_v[STICK_W-1], win_v};
   assign dz_pos  = {1'b0, dz_eff};
   assign dz_neg  = -dz_pos;

   always_comb begin
      priority if (win_ext > dz_pos) begin
         move_calc = MOVE_POS;
      end else if (win_ext < dz_neg) begin
         move_calc = MOVE_NEG;
      end else begin
         move_calc = MOVE_NONE;
      end
   end

   // ---------------------------------------------------------------
   // Hold tracking. State advances only when a beat enters the result
   // register, so it follows beat order exactly.
   // ---------------------------------------------------------------
   logic       was_pressed_ff, was_pressed_in;
   hold_type   held_ms_ff, held_ms_in;
   logic [HOLD_W:0] held_sum;
   hold_type   held_sat;
   logic       release_evt;
   logic       pause_calc, reset_calc, quit_calc;

   assign held_sum    = {1'b0, held_ms_ff} + {{(HOLD_W+1-TICK_W){1'b0}}, tick_ms_ff};
   assign held_sat    = held_sum[HOLD_W] ? HELD_MAX : held_sum[HOLD_W-1:0];
   assign release_evt = was_pressed_ff & ~s0_btn_ff;

   // quit beats reset, reset beats pause
   always_comb begin
      pause_calc = 1'b0;
      reset_calc = 1'b0;
      quit_calc  = 1'b0;
      if (release_evt) begin
         priority if (held_ms_ff >= quit_hold_ff) begin
            quit_calc = 1'b1;
         end else if (held_ms_ff >= reset_hold_ff) begin
            reset_calc = 1'b1;
         end else begin
            pause_calc = 1'b1;
         end
      end
   end

   always_comb begin
      was_pressed_in = was_pressed_ff;
      held_ms_in     = held_ms_ff;
      if (s0_fire) begin
         was_pressed_in = s0_btn_ff;
         if (s0_btn_ff) begin
            // press edge restarts the count at zero
            held_ms_in = was_pressed_ff ? held_sat : '0;
         end else if (release_evt) begin
            held_ms_in = '0;
         end
      end
   end

   // ---------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------
   assign s1_valid_in = s0_fire | (s1_valid_ff & ~rsp_chan.ready);
   assign s1_move_in  = s0_fire ? move_calc  : s1_move_ff;
   assign s1_pause_in = s0_fire ? pause_calc : s1_pause_ff;
   assign s1_reset_in = s0_fire ? reset_calc : s1_reset_ff;
   assign s1_quit_in  = s0_fire ? quit_calc  : s1_quit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff    <= 1'b0;
         s1_valid_ff    <= 1'b0;
         was_pressed_ff <= 1'b0;
         held_ms_ff     <= '0;
      end else begin
         s0_valid_ff    <= s0_valid_in;
         s1_valid_ff    <= s1_valid_in;
         was_pressed_ff <= was_pressed_in;
         held_ms_ff     <= held_ms_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      s0_x_ff     <= s0_x_in;
      s0_y_ff     <= s0_y_in;
      s0_btn_ff   <= s0_btn_in;
      s1_move_ff  <= s1_move_in;
      s1_pause_ff <= s1_pause_in;
      s1_reset_ff <= s1_reset_in;
      s1_quit_ff  <= s1_quit_in;
   end

   assign rsp_chan.valid       = s1_valid_ff;
   assign rsp_chan.move        = s1_move_ff;
   assign rsp_chan.pause_pulse = s1_pause_ff;
   assign rsp_chan.reset_pulse = s1_reset_ff;
   assign rsp_chan.quit_pulse  = s1_quit_ff;

`ifndef NO_ASSERTIONS
   // at most one of the release pulses per result
   a_pulse_onehot: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> $onehot0({s1_pause_ff, s1_reset_ff, s1_quit_ff}))
      else $error("more than one release pulse in a result");

   // counter is empty after a released frame goes through
   a_release_clears: assert property (@(posedge clock) disable iff (reset)
      (s0_fire && !s0_btn_ff) |=> (held_ms_ff == '0))
      else $error("hold counter not clear after release");

   // a pressed frame leaves the press state set
   a_press_tracks: assert property (@(posedge clock) disable iff (reset)
      (s0_fire && s0_btn_ff) |=> was_pressed_ff)
      else $error("press state lost");

   // while held, the counter never goes down
   a_hold_monotonic: assert property (@(posedge clock) disable iff (reset)
      (s0_fire && s0_btn_ff && was_pressed_ff) |=> (held_ms_ff >= $past(held_ms_ff)))
      else $error("hold counter decreased during hold");
`endif

endmodule

### test/jdpc_frame_checker.sv
`timescale 1ns / 1ps

module jdpc_frame_checker import jdpc_pkg::*; (
   input  logic clock,
   input  logic reset,
   jdpc_req_if  req_mon,
   jdpc_rsp_if  rsp_mon,
   jdpc_csr_if  csr_mon,
   output int   mismatches,
   output int   outstanding
);

   typedef struct packed {
      move_type move;
      logic     pause_pulse;
      logic     reset_pulse;
      logic     quit_pulse;
   } frame_result_type;

   frame_result_type expected_frames[$];
   frame_result_type oldest;

   // shadow registers and press state
   int   dz_reg;
   int   tick_reg;
   int   quit_reg;
   int   restart_reg;
   logic last_button;
   int   hold_ms;

   function automatic frame_result_type classify_frame(stick_type x, stick_type y, logic btn);
      frame_result_type r;
      int ax;
      int ay;
      int lead;
      int dz;
      int sum;
      ax   = (x < 0) ? -int'(x) : int'(x);
      ay   = (y < 0) ? -int'(y) : int'(y);
      lead = (ax >= ay) ? int'(x) : int'(y);
      dz   = (dz_reg < int'(DZ_FLOOR)) ? int'(DZ_FLOOR) : dz_reg;
      if (lead > dz)
         r.move = MOVE_POS;
      else if (lead < -dz)
         r.move = MOVE_NEG;
      else
         r.move = MOVE_NONE;
      r.pause_pulse = 1'b0;
      r.reset_pulse = 1'b0;
      r.quit_pulse  = 1'b0;
      if (btn) begin
         sum     = hold_ms + tick_reg;
         hold_ms = (sum > int'(HELD_MAX)) ? int'(HELD_MAX) : sum;
      end
      // tick lands first, then the press edge wipes it
      if (!last_button && btn)
         hold_ms = 0;
      if (last_button && !btn) begin
         if (hold_ms >= quit_reg)
            r.quit_pulse = 1'b1;
         else if (hold_ms >= restart_reg)
            r.reset_pulse = 1'b1;
         else
            r.pause_pulse = 1'b1;
         hold_ms = 0;
      end
      last_button = btn;
      return r;
   endfunction

   task automatic check_field(string name, logic signed [1:0] want, logic signed [1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_frames.delete();
         dz_reg      = int'(DEAD_ZONE_RST);
         tick_reg    = int'(TICK_MS_RST);
         quit_reg    = int'(QUIT_HOLD_RST);
         restart_reg = int'(RESET_HOLD_RST);
         last_button = 1'b0;
         hold_ms     = 0;
         mismatches  = 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.addr)
               REG_DEAD_ZONE:  dz_reg      = int'(csr_mon.wdata[DZ_W-1:0]);
               REG_TICK_MS:    tick_reg    = int'(csr_mon.wdata[TICK_W-1:0]);
               REG_QUIT_HOLD:  quit_reg    = int'(csr_mon.wdata[HOLD_W-1:0]);
               REG_RESET_HOLD: restart_reg = int'(csr_mon.wdata[HOLD_W-1:0]);
               default: ;
            endcase
         end
         // pop before push: a beat cannot answer a frame taken on the same edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_frames.size() == 0) begin
               $error("rsp beat with no frame outstanding");
               mismatches++;
            end else begin
               oldest = expected_frames.pop_front();
               check_field("move", oldest.move, rsp_mon.move);
               check_field("pause_pulse", {1'b0, oldest.pause_pulse},
                           {1'b0, rsp_mon.pause_pulse});
               check_field("reset_pulse", {1'b0, oldest.reset_pulse},
                           {1'b0, rsp_mon.reset_pulse});
               check_field("quit_pulse", {1'b0, oldest.quit_pulse},
                           {1'b0, rsp_mon.quit_pulse});
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_frames.push_back(classify_frame(req_mon.stick_x, req_mon.stick_y,
                                                     req_mon.button_down));
      end
      outstanding = expected_frames.size();
   end

endmodule

### test/tb_joystick_deadzone_press_classifier.sv
`timescale 1ns / 1ps

module tb_joystick_deadzone_press_classifier;
   import jdpc_pkg::*;

   // two register stages between req and rsp
   localparam int PIPE_LATENCY = 2;

   // rsp.ready patterns
   typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_THIRD_LOW, RDY_SPARSE} ready_mode_type;

   logic clock;
   logic reset;
   int   mismatches;
   int   outstanding;

   // beats left in the current req burst
   int   burst_left;

   // copy of the register settings, only used to steer stimulus
   int   cur_dz;
   int   cur_tick;
   int   cur_quit;
   int   cur_restart;

   jdpc_req_if req_bus ();
   jdpc_rsp_if rsp_bus ();
   jdpc_csr_if csr_bus ();

   joystick_deadzone_press_classifier i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   jdpc_frame_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .csr_mon     (csr_bus),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop, far above the slowest legal run
   initial begin
      #2ms;
      $display("Mismatches found");
      $finish;
   end

   // rsp.ready: random-length runs of one pattern, independent of the sender
   initial begin
      ready_mode_type mode;
      int             mode_left;
      int             cyc;
      rsp_bus.ready <= 1'b0;
      mode      = RDY_ALWAYS;
      mode_left = 0;
      cyc       = 0;
      forever begin
         @(posedge clock);
         if (mode_left == 0) begin
            mode      = ready_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(10, 120);
         end
         mode_left--;
         cyc++;
         case (mode)
            RDY_ALWAYS:    rsp_bus.ready <= 1'b1;
            RDY_COIN:      rsp_bus.ready <= ($urandom_range(0, 3) != 0);
            RDY_THIRD_LOW: rsp_bus.ready <= (cyc % 3 != 0);
            default:       rsp_bus.ready <= (cyc % 8 == 7);
         endcase
      end
   end

   // One frame beat. Called right after a rising edge; returns right after
   // the edge that took the beat. Gaps only open between bursts, and valid
   // is only lowered when a gap really follows.
   task automatic send_frame(input int x, input int y, input bit btn);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150)
                                                  : $urandom_range(1, 20);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_bus.valid       <= 1'b1;
      req_bus.stick_x     <= stick_type'(x);
      req_bus.stick_y     <= stick_type'(y);
      req_bus.button_down <= btn;
      do @(posedge clock); while (!req_bus.ready);
      burst_left--;
   endtask

   // Hold req off until every frame has been answered. The count is polled
   // on the falling edge, away from the checker's update.
   task automatic drain();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      @(posedge clock);
   endtask

   // Writes all four registers back to back; only called while idle.
   task automatic write_config(input int dz_word, input int tick_word,
                               input int quit_word, input int restart_word);
      csr_addr_type idx [4];
      int           val [4];
      idx = '{REG_DEAD_ZONE, REG_TICK_MS, REG_QUIT_HOLD, REG_RESET_HOLD};
      val = '{dz_word, tick_word, quit_word, restart_word};
      for (int i = 0; i < 4; i++) begin
         csr_bus.valid <= 1'b1;
         csr_bus.addr  <= idx[i];
         csr_bus.wdata <= csr_data_type'(val[i]);
         do @(posedge clock); while (!csr_bus.ready);
      end
      csr_bus.valid <= 1'b0;
      cur_dz      = int'(dz_type'(dz_word));
      cur_tick    = int'(tick_type'(tick_word));
      cur_quit    = int'(hold_type'(quit_word));
      cur_restart = int'(hold_type'(restart_word));
   endtask

   // Random config. Thresholds are mostly small multiples of the tick so
   // that holds of a few dozen frames land on either side of them; junk in
   // the unused upper bits of the narrow registers must be dropped.
   task automatic random_config();
      int tick;
      int quit;
      int rst;
      tick = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(1, 200);
      quit = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                         : tick * $urandom_range(0, 60);
      rst  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                         : tick * $urandom_range(0, 40);
      if (quit > 65535) quit = 65535;
      if (rst > 65535)  rst  = 65535;
      write_config($urandom_range(0, 65535), ($urandom_range(0, 63) << 10) | tick, quit, rst);
   endtask

   // Press length in frames. The first pressed frame adds nothing, so n
   // frames hold for (n-1) ticks; aim just below, at and just past a limit.
   function automatic int pick_hold_frames();
      int target;
      int frames;
      case ($urandom_range(0, 4))
         0:       target = cur_restart;
         1:       target = cur_quit;
         2:       target = (cur_tick >= 400) ? int'(HELD_MAX) : -1;
         default: target = -1;
      endcase
      if (target < 0 || cur_tick == 0)
         return $urandom_range(1, 6);
      frames = (target + cur_tick - 1) / cur_tick + int'($urandom_range(0, 2));
      if (frames < 1)   frames = 1;
      if (frames > 150) frames = 150;
      return frames;
   endfunction

   // Stick value: mostly uniform, else one step around the dead zone edge.
   function automatic int rand_stick();
      int dz;
      int v;
      dz = (cur_dz < int'(DZ_FLOOR)) ? int'(DZ_FLOOR) : cur_dz;
      if ($urandom_range(0, 3) != 0)
         return int'($urandom_range(0, 255)) - 128;
      v = dz + int'($urandom_range(0, 2)) - 1;
      if ($urandom_range(0, 1) == 1) v = -v;
      if (v > 127)  v = 127;
      if (v < -128) v = -128;
      return v;
   endfunction

   // Mostly press/hold/release sequences, some random button noise.
   task automatic run_phase(input int n_frames);
      int sent;
      sent = 0;
      while (sent < n_frames) begin
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 6)) begin
               send_frame(rand_stick(), rand_stick(), 1'($urandom_range(0, 1)));
               sent++;
            end
         end else begin
            repeat (pick_hold_frames()) begin
               send_frame(rand_stick(), rand_stick(), 1'b1);
               sent++;
            end
            repeat ($urandom_range(1, 3)) begin
               send_frame(rand_stick(), rand_stick(), 1'b0);
               sent++;
            end
         end
      end
   endtask

   initial begin
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.stick_x     <= '0;
      req_bus.stick_y     <= '0;
      req_bus.button_down <= 1'b0;
      csr_bus.valid       <= 1'b0;
      csr_bus.addr        <= REG_DEAD_ZONE;
      csr_bus.wdata       <= '0;
      burst_left  = 0;
      cur_dz      = int'(DEAD_ZONE_RST);
      cur_tick    = int'(TICK_MS_RST);
      cur_quit    = int'(QUIT_HOLD_RST);
      cur_restart = int'(RESET_HOLD_RST);
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // --- directed, reset settings (dead zone 80) ---
      send_frame(127, 0, 1'b0);      // full right
      send_frame(-128, 0, 1'b0);     // full left, magnitude 128
      send_frame(0, 127, 1'b0);      // Y wins
      send_frame(0, -128, 1'b0);
      send_frame(80, -80, 1'b0);     // tie on the dead zone edge: still inside
      send_frame(81, -81, 1'b0);     // tie goes to X: right
      send_frame(-81, 81, 1'b0);     // tie goes to X: left
      send_frame(-128, 127, 1'b0);   // X wins by one
      send_frame(127, -128, 1'b0);   // Y wins by one
      send_frame(0, 0, 1'b1);        // press edge
      send_frame(-1, -1, 1'b1);
      send_frame(0, 0, 1'b0);        // short tap: pause
      send_frame(5, 81, 1'b1);
      send_frame(0, 0, 1'b0);        // single frame press: pause
      drain();

      // --- directed, dead zone below floor, 1000 ms per frame ---
      write_config(0, 1000, 3000, 1000);
      send_frame(0, 0, 1'b1);
      send_frame(0, 0, 1'b1);        // 1000 ms
      send_frame(-79, 0, 1'b0);      // reset threshold met exactly
      repeat (4) send_frame(0, 0, 1'b1);   // 3000 ms
      send_frame(0, 0, 1'b0);        // quit threshold met exactly
      drain();

      // --- fixed corners ---
      // widest dead zone, max tick, both thresholds at the saturation value
      write_config(255, 1023, 65535, 65535);
      run_phase(90);
      drain();
      // zero tick, zero thresholds: every release quits
      write_config(127, 0, 0, 0);
      run_phase(60);
      drain();
      // crossed thresholds, dead zone just below the floor
      write_config(79, 1, 5, 10);
      run_phase(80);
      drain();
      write_config(81, 512, 20000, 2000);
      run_phase(90);
      drain();
      write_config(int'(DEAD_ZONE_RST), int'(TICK_MS_RST), int'(QUIT_HOLD_RST),
                   int'(RESET_HOLD_RST));
      run_phase(150);
      drain();

      // --- random settings ---
      repeat (7) begin
         random_config();
         run_phase(90);
         drain();
      end

      // catch any stray beat after the last answer
      repeat (4 * PIPE_LATENCY) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
